>>> rtl/event_subscription_table_assert.svh
// assertion macros for the event subscription table
// no dependencies; compiled to empty bodies when SYNTHESIS is defined
`ifndef EVENT_SUBSCRIPTION_TABLE_ASSERT_SVH
`define EVENT_SUBSCRIPTION_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EST_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define EST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define EST_ASSERT_IMP(name, clk, rst, ante, cons)
`define EST_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> rtl/est_pkg.sv
// shared constants, types and helpers of the event subscription table
// no dependencies
`default_nettype none
package est_pkg;

   localparam int NUM_EVENTS      = 16;
   localparam int SLOTS_PER_EVENT = 8;

   localparam int FUNC_W = 2;
   localparam int EV_W   = 8;
   localparam int ID_W   = 16;
   localparam int PAY_W  = 32;

   localparam int ROW_W  = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int SLOT_W = (SLOTS_PER_EVENT > 1) ? $clog2(SLOTS_PER_EVENT) : 1;

   localparam int REQ_FIELDS_W = EV_W + ID_W + PAY_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + ID_W + EV_W + PAY_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [FUNC_W-1:0] FUNC_SUBSCRIBE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UNSUBSCRIBE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PUBLISH     = 2'd2;

   localparam logic KIND_STATUS   = 1'b0;
   localparam logic KIND_DELIVERY = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_FAIL   = 1'b1;

   typedef logic [ID_W-1:0] id_type;
   typedef logic [SLOTS_PER_EVENT-1:0][ID_W-1:0] row_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } pick_type;

   typedef struct packed {
      logic             rd_en;
      logic [ROW_W-1:0] rd_addr;
      logic             wr_en;
      logic [ROW_W-1:0] wr_addr;
      row_type          wr_data;
   } mem_req_type;

   // lowest set bit of a slot mask
   function automatic pick_type first_set(input logic [SLOTS_PER_EVENT-1:0] mask);
      pick_type p;
      p = '0;
      for (int i = SLOTS_PER_EVENT - 1; i >= 0; i--) begin
         if (mask[i]) begin
            p.found = 1'b1;
            p.idx   = SLOT_W'(i);
         end
      end
      return p;
   endfunction

endpackage
`default_nettype wire

>>> rtl/est_row_mem.sv
// row memory of the subscription table: one row of slots per event
// depends on est_pkg; rows never written read as all empty
`default_nettype none
module est_row_mem
   import est_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mem_req_type req,
   output logic             row_type_unused_n,
   output row_type          rd_data
);

   row_type                 mem_ff [NUM_EVENTS];
   logic [NUM_EVENTS-1:0]   valid_ff;
   row_type                 rd_data_ff;

   // per-row written flags stand in for clearing the array at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= valid_ff[req.rd_addr] ? mem_ff[req.rd_addr] : '0;
      end
   end

   assign rd_data           = rd_data_ff;
   assign row_type_unused_n = 1'b1;

endmodule
`default_nettype wire

>>> rtl/est_slot_pick.sv
// priority pick of the lowest slot of a row equal to a key
// depends on est_pkg
`default_nettype none
module est_slot_pick
   import est_pkg::*;
(
   input  wire row_type  row,
   input  wire id_type   key,
   output pick_type      pick
);

   logic [SLOTS_PER_EVENT-1:0] hit;

   always_comb begin
      for (int i = 0; i < SLOTS_PER_EVENT; i++) begin
         hit[i] = (row[i] == key);
      end
      pick = first_set(hit);
   end

endmodule
`default_nettype wire

>>> rtl/event_subscription_table.sv
// channel | dir | beat contents
// req_*   | in  | tuser: func; tdata: event_number, subscriber_id, payload
// rsp_*   | out | tuser: item_kind; tlast: last; tdata: status, target_id, event_out, payload_out
//
// subscribe, unsubscribe and failed operations: accept with row read in S_IDLE, then pick
// and write-back with the status beat in S_PICK, after the registered row memory read.
// publish: mask load in S_PICK, then one delivery beat a cycle from the held row unless stalled.
// reset clears per-row written flags at once; no clearing pass, ready right after reset.
// rsp_tready low holds the result register and stalls the sequencer; req_tready is low
// while an item is in progress.
//
// top level of the event subscription table; depends on est_pkg, est_row_mem,
// est_slot_pick and event_subscription_table_assert.svh
`default_nettype none
`include "event_subscription_table_assert.svh"
module event_subscription_table
   import est_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: event_number[7:0], subscriber_id[23:8], payload[55:24]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: func[1:0]
   input  wire logic [FUNC_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: status[0], target_id[16:1], event_out[24:17], payload_out[56:25], zeros above
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: item_kind
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PICK = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [FUNC_W-1:0]          func_ff;
   logic [EV_W-1:0]            ev_ff;
   id_type                     id_ff;
   logic [PAY_W-1:0]           pay_ff;
   logic                       op_ok_ff;
   logic [SLOTS_PER_EVENT-1:0] mask_ff, mask_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic                       rsp_status_ff, rsp_status_in;
   id_type                     rsp_target_ff, rsp_target_in;
   logic [EV_W-1:0]            rsp_event_ff;
   logic [PAY_W-1:0]           rsp_payload_ff, rsp_payload_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_fire;
   logic                       out_free;
   logic                       emit;
   logic [EV_W-1:0]            req_event;
   logic                       req_in_range;
   mem_req_type                mem_req;
   row_type                    row;
   row_type                    new_row;
   logic                       mem_flag_n;
   id_type                     key;
   pick_type                   pick;
   pick_type                   next_sub;

   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_event    = req_tdata[EV_W-1:0];
   assign req_in_range = ({1'b0, req_event} < (EV_W + 1)'(NUM_EVENTS));

   est_row_mem u_mem (
      .clock             (clock),
      .reset             (reset),
      .req               (mem_req),
      .row_type_unused_n (mem_flag_n),
      .rd_data           (row)
   );

   // subscribe looks for the lowest empty slot, unsubscribe for the id
   assign key = (func_ff == FUNC_SUBSCRIBE) ? '0 : id_ff;

   est_slot_pick u_pick (
      .row  (row),
      .key  (key),
      .pick (pick)
   );

   assign next_sub = first_set(mask_ff);

   always_comb begin
      new_row = row;
      new_row[pick.idx] = (func_ff == FUNC_SUBSCRIBE) ? id_ff : '0;
   end

   always_comb begin
      mem_req.rd_en   = req_fire;
      mem_req.rd_addr = req_event[ROW_W-1:0];
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ev_ff[ROW_W-1:0];
      mem_req.wr_data = new_row;

      state_in       = state_ff;
      mask_in        = mask_ff;
      emit           = 1'b0;
      rsp_kind_in    = KIND_STATUS;
      rsp_status_in  = STATUS_OK;
      rsp_target_in  = '0;
      rsp_payload_in = '0;
      rsp_last_in    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (!op_ok_ff) begin
               if (out_free) begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_FAIL;
                  state_in      = S_IDLE;
               end
            end else if (func_ff == FUNC_PUBLISH) begin
               for (int i = 0; i < SLOTS_PER_EVENT; i++) begin
                  mask_in[i] = (row[i] != '0);
               end
               state_in = S_EMIT;
            end else if (out_free) begin
               emit           = 1'b1;
               mem_req.wr_en  = pick.found;
               rsp_status_in  = pick.found ? STATUS_OK : STATUS_FAIL;
               state_in       = S_IDLE;
            end
         end
         S_EMIT: begin
            // row stays on the memory output until the next accepted beat
            if (out_free) begin
               emit = 1'b1;
               if (next_sub.found) begin
                  rsp_kind_in           = KIND_DELIVERY;
                  rsp_target_in         = row[next_sub.idx];
                  rsp_payload_in        = pay_ff;
                  rsp_last_in           = 1'b0;
                  mask_in[next_sub.idx] = 1'b0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (req_fire) begin
         func_ff  <= req_tuser;
         ev_ff    <= req_event;
         id_ff    <= req_tdata[EV_W +: ID_W];
         pay_ff   <= req_tdata[EV_W + ID_W +: PAY_W];
         op_ok_ff <= req_in_range && (req_tuser == FUNC_SUBSCRIBE ||
                     req_tuser == FUNC_UNSUBSCRIBE || req_tuser == FUNC_PUBLISH) && mem_flag_n;
      end
      if (out_free && emit) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_target_ff  <= rsp_target_in;
         rsp_event_ff   <= ev_ff;
         rsp_payload_ff <= rsp_payload_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_payload_ff, rsp_event_ff, rsp_target_ff,
                        rsp_status_ff};

   `EST_ASSERT_NEXT(a_accept_to_pick, clock, reset, req_fire, state_ff == S_PICK)
   `EST_ASSERT_IMP(a_write_in_pick, clock, reset, mem_req.wr_en, state_ff == S_PICK && op_ok_ff)
   `EST_ASSERT_IMP(a_last_is_status, clock, reset, rsp_tvalid && rsp_tlast,
      rsp_tuser == KIND_STATUS)
   `EST_ASSERT_IMP(a_delivery_nonzero, clock, reset, rsp_tvalid && rsp_tuser == KIND_DELIVERY,
      rsp_target_ff != '0 && !rsp_tlast)

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for event_subscription_table: random and directed table operations
// driven on the req stream, results on the rsp stream checked against a shadow slot table
// depends on est_pkg and the event_subscription_table rtl
module tb
   import est_pkg::*;
();

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_STALL = 300;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [EV_W-1:0]   event_num;
      id_type            sub_id;
      logic [PAY_W-1:0]  payload;
   } table_op_type;

   typedef struct packed {
      logic             kind;
      logic             status;
      id_type           target;
      logic [EV_W-1:0]  event_num;
      logic [PAY_W-1:0] payload;
      logic             last;
   } table_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   table_op_type  pending_ops[$];
   table_rsp_type expected_rsp[$];
   id_type        shadow_slots [NUM_EVENTS][SLOTS_PER_EVENT] = '{default: '0};

   bit          req_beat_seen = 1'b0;
   bit          quiet = 1'b0;
   bit          want_long_stall = 1'b0;
   int          stall_left = 0;
   int unsigned cycles = 0;
   int          mismatches = 0;
   int          ops_accepted = 0;
   int          rsp_beats = 0;
   int          deliveries_seen = 0;
   int          failed_status_seen = 0;

   event_subscription_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // works out the beats one operation produces and updates the shadow table
   function automatic void model_table_op(input table_op_type op);
      table_rsp_type r;
      table_rsp_type dlv;
      id_type        look;
      int            hit;
      r = '0;
      r.kind      = KIND_STATUS;
      r.event_num = op.event_num;
      r.last      = 1'b1;
      if (op.event_num >= NUM_EVENTS || op.func == FUNC_UNUSED) begin
         r.status = STATUS_FAIL;
         expected_rsp.push_back(r);
         return;
      end
      case (op.func)
         FUNC_SUBSCRIBE, FUNC_UNSUBSCRIBE: begin
            // subscribe looks for an empty slot, unsubscribe for the id itself
            look = (op.func == FUNC_SUBSCRIBE) ? '0 : op.sub_id;
            hit = -1;
            for (int s = 0; s < SLOTS_PER_EVENT; s++)
               if (hit < 0 && shadow_slots[op.event_num][s] == look) hit = s;
            if (hit >= 0)
               shadow_slots[op.event_num][hit] = (op.func == FUNC_SUBSCRIBE) ? op.sub_id : '0;
            r.status = (hit >= 0) ? STATUS_OK : STATUS_FAIL;
         end
         default: begin
            for (int s = 0; s < SLOTS_PER_EVENT; s++) begin
               if (shadow_slots[op.event_num][s] != '0) begin
                  dlv           = '0;
                  dlv.kind      = KIND_DELIVERY;
                  dlv.status    = STATUS_OK;
                  dlv.target    = shadow_slots[op.event_num][s];
                  dlv.event_num = op.event_num;
                  dlv.payload   = op.payload;
                  expected_rsp.push_back(dlv);
               end
            end
            r.status = STATUS_OK;
         end
      endcase
      expected_rsp.push_back(r);
   endfunction

   function automatic table_op_type random_op();
      table_op_type op;
      int           roll;
      int           pick;
      roll = $urandom_range(99);
      op.payload = $urandom;
      pick = $urandom_range(19);
      if (pick == 0) op.sub_id = '0;
      else if (pick < 4) op.sub_id = id_type'($urandom);
      else op.sub_id = id_type'($urandom_range(1, 6));
      // a few hot rows so that rows fill up, duplicate and drain
      if ($urandom_range(9) < 7) op.event_num = EV_W'($urandom_range(3));
      else op.event_num = EV_W'($urandom_range(NUM_EVENTS - 1));
      if (roll < 3) begin
         op.func = FUNC_UNUSED;
         op.event_num = EV_W'($urandom_range(255));
      end else if (roll < 6) begin
         op.func = FUNC_W'($urandom_range(2));
         op.event_num = EV_W'($urandom_range(NUM_EVENTS, 255));
      end else if (roll < 48) begin
         op.func = FUNC_SUBSCRIBE;
      end else if (roll < 72) begin
         op.func = FUNC_UNSUBSCRIBE;
      end else begin
         op.func = FUNC_PUBLISH;
      end
      return op;
   endfunction

   task automatic push_op(input logic [FUNC_W-1:0] func, input int ev, input id_type id,
                          input logic [PAY_W-1:0] pay);
      table_op_type op;
      op.func      = func;
      op.event_num = EV_W'(ev);
      op.sub_id    = id;
      op.payload   = pay;
      pending_ops.push_back(op);
   endtask

   task automatic push_random(input int count);
      repeat (count) pending_ops.push_back(random_op());
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("beat %0d: %s is %0h, wanted %0h", rsp_beats, what, got, want);
      mismatches++;
   endtask

   // request driver: new beat only once the previous one has gone
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_beat_seen)) begin
         if (pending_ops.size() != 0 && (quiet || $urandom_range(99) >= 17)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'({pending_ops[0].payload, pending_ops[0].sub_id,
                                       pending_ops[0].event_num});
            req_tuser  <= pending_ops[0].func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_beat_seen = !reset && req_tvalid && req_tready;
      if (req_beat_seen) begin
         model_table_op(pending_ops[0]);
         void'(pending_ops.pop_front());
         ops_accepted++;
      end
   end

   // result back-pressure, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (want_long_stall) begin
         want_long_stall = 1'b0;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 17);
      end
   end

   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_beats++;
         if (rsp_tuser == KIND_DELIVERY) deliveries_seen++;
         else if (rsp_tdata[0] == STATUS_FAIL) failed_status_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected beat, tdata", 64'(rsp_tdata), '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("item_kind", 64'(rsp_tuser), 64'(want.kind));
            if (rsp_tdata[0] !== want.status)
               report_mismatch("status", 64'(rsp_tdata[0]), 64'(want.status));
            if (rsp_tdata[16:1] !== want.target)
               report_mismatch("target_id", 64'(rsp_tdata[16:1]), 64'(want.target));
            if (rsp_tdata[24:17] !== want.event_num)
               report_mismatch("event_out", 64'(rsp_tdata[24:17]), 64'(want.event_num));
            if (rsp_tdata[56:25] !== want.payload)
               report_mismatch("payload_out", 64'(rsp_tdata[56:25]), 64'(want.payload));
            if ((rsp_tdata >> RSP_FIELDS_W) !== '0)
               report_mismatch("tdata padding", 64'(rsp_tdata >> RSP_FIELDS_W), '0);
            if (rsp_tlast !== want.last)
               report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                  expected_rsp.size());
         $display("event_subscription_table: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty row, no-match unsubscribe
      push_op(FUNC_PUBLISH, 0, 16'h0000, 32'h1234_5678);
      push_op(FUNC_UNSUBSCRIBE, 0, 16'h0001, 32'h0);
      // fill the top row, with a duplicate id
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'hFFFF, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0001, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h8000, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h8000, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0002, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0003, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0004, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0005, 32'h0);
      // full row: subscribe, null unsubscribe and null subscribe all fail
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0006, 32'h0);
      push_op(FUNC_UNSUBSCRIBE, NUM_EVENTS - 1, 16'h0000, 32'h0);
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0000, 32'h0);
      push_op(FUNC_PUBLISH, NUM_EVENTS - 1, 16'h0000, 32'hFFFF_FFFF);
      push_op(FUNC_UNSUBSCRIBE, NUM_EVENTS - 1, 16'h8000, 32'h0);
      // null id on a row with a hole succeeds and changes nothing
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS - 1, 16'h0000, 32'h0);
      push_op(FUNC_UNSUBSCRIBE, NUM_EVENTS - 1, 16'h0000, 32'h0);
      push_op(FUNC_PUBLISH, NUM_EVENTS - 1, 16'hFFFF, 32'h0000_0000);
      // out of range events and the unused code
      push_op(FUNC_SUBSCRIBE, NUM_EVENTS, 16'h0007, 32'h0);
      push_op(FUNC_UNSUBSCRIBE, 255, 16'hFFFF, 32'h0);
      push_op(FUNC_PUBLISH, 255, 16'hFFFF, 32'hFFFF_FFFF);
      push_op(FUNC_UNUSED, 0, 16'h0001, 32'h5A5A_5A5A);
      push_op(FUNC_UNUSED, 255, 16'hFFFF, 32'hFFFF_FFFF);
      wait_drained();

      push_random(120);
      wait_drained();

      // hold the result side while requests keep coming
      want_long_stall = 1'b1;
      push_random(120);
      wait_drained();

      // no idling on either side
      quiet = 1'b1;
      push_random(120);
      wait_drained();
      quiet = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d operations in %0d cycles: %0d deliveries, %0d status beats failed",
               ops_accepted, cycles, deliveries_seen, failed_status_seen);
      $display("covered full, empty and duplicate rows, null ids, bad events and stalls");
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("event_subscription_table: match");
      end else begin
         $display("%0d mismatches, %0d beats missing", mismatches, expected_rsp.size());
         $display("event_subscription_table: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/est_pkg.sv
rtl/est_row_mem.sv
rtl/est_slot_pick.sv
rtl/event_subscription_table.sv
sim/tb.sv
